// ===== design/bad_block_remap_allocator_macros.svh =====
`ifndef BAD_BLOCK_REMAP_ALLOCATOR_MACROS_SVH
`define BAD_BLOCK_REMAP_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define BBRA_ASSERT_IMP(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("bbra assertion failed");

// next-cycle implication, disabled during reset
`define BBRA_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error("bbra assertion failed");

`endif

// ===== design/bbra_pkg.sv =====
package bbra_pkg;

    localparam int OPCODE_W = 2;
    localparam int BLOCK_W  = 5;
    localparam int LEN_W    = 6;
    localparam int STATUS_W = 2;
    localparam int SKIP_W   = 6;
    localparam int KIND_W   = 2;
    localparam int STOP_W   = 7;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD_BAD,
        OP_ALLOC,
        OP_ACCESS,
        OP_QUERY
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK,
        STS_NO_SPARE,
        STS_ALLOCATED,
        STS_RANGE
    } status_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_FREE,
        KIND_USED,
        KIND_BAD,
        KIND_SPARE
    } kind_t;

    typedef enum logic [1:0] {
        BS_FREE,
        BS_USED,
        BS_BAD
    } blk_state_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_BSCAN,
        S_MSCAN,
        S_FINISH
    } ctl_state_t;

    typedef struct packed {
        logic              valid;
        logic              live;
        logic              conflict;
        logic [SKIP_W-1:0] skipped;
        kind_t             kind;
    } blk_tok_t;

    typedef struct packed {
        logic               alloc_mode;
        logic               bad_we;
        logic [BLOCK_W-1:0] first;
        logic [STOP_W-1:0]  stop;
    } blk_ctl_t;

    typedef struct packed {
        logic               valid;
        logic               found;
        logic [BLOCK_W-1:0] target;
    } map_tok_t;

    typedef struct packed {
        logic               we;
        logic [BLOCK_W-1:0] key;
    } map_ctl_t;

    typedef struct packed {
        status_t            status;
        logic [BLOCK_W-1:0] target;
        logic               redirected;
        logic [SKIP_W-1:0]  skipped;
        kind_t              kind;
    } rsp_t;

endpackage

// ===== design/bbra_in_if.sv =====
interface bbra_in_if import bbra_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [BLOCK_W-1:0]  block;
    logic [LEN_W-1:0]    run_length;

    modport source (output valid, output opcode, output block, output run_length, input ready);
    modport sink (input valid, input opcode, input block, input run_length, output ready);
endinterface

// ===== design/bbra_out_if.sv =====
interface bbra_out_if import bbra_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BLOCK_W-1:0]  target_block;
    logic                redirected;
    logic [SKIP_W-1:0]   bad_skipped;
    logic [KIND_W-1:0]   block_kind;

    modport source (output valid, output status, output target_block, output redirected,
                    output bad_skipped, output block_kind, input ready);
    modport sink (input valid, input status, input target_block, input redirected,
                  input bad_skipped, input block_kind, output ready);
endinterface

// ===== design/bbra_block_cell.sv =====
module bbra_block_cell import bbra_pkg::*; #(
    parameter int CELL_IDX = 0,
    parameter bit IS_SPARE = 1'b0
) (
    input  logic     clk,
    input  logic     rst_n,
    input  blk_ctl_t ctl,
    input  blk_tok_t tok_in,
    output blk_tok_t tok_out
);

    localparam bit                REACH  = CELL_IDX < (2 ** STOP_W);
    localparam logic [STOP_W-1:0] MY_IDX = STOP_W'(CELL_IDX);

    blk_state_t state_reg;
    blk_state_t state_next;
    blk_tok_t   tok_reg;
    blk_tok_t   tok_next;
    logic       hit;
    logic       in_range;

    assign hit      = REACH && (MY_IDX == {{(STOP_W-BLOCK_W){1'b0}}, ctl.first});
    assign in_range = REACH && (MY_IDX >= {{(STOP_W-BLOCK_W){1'b0}}, ctl.first})
                      && (MY_IDX < ctl.stop);

    always_comb
    begin
        state_next = state_reg;
        tok_next   = tok_in;
        if (ctl.bad_we && hit)
        begin
            state_next = BS_BAD;
        end
        if (tok_in.valid)
        begin
            if (ctl.alloc_mode)
            begin
                if (tok_in.live && in_range)
                begin
                    unique case (state_reg)
                        BS_BAD:
                        begin
                            tok_next.skipped = tok_in.skipped + SKIP_W'(1);
                        end
                        BS_USED:
                        begin
                            tok_next.conflict = 1'b1;
                            tok_next.live     = 1'b0;
                        end
                        BS_FREE:
                        begin
                            state_next = BS_USED;
                        end
                        default:
                        begin
                            state_next = state_reg;
                        end
                    endcase
                end
            end
            else if (hit)
            begin
                priority if (state_reg == BS_BAD)
                    tok_next.kind = KIND_BAD;
                else if (IS_SPARE)
                    tok_next.kind = KIND_SPARE;
                else if (state_reg == BS_USED)
                    tok_next.kind = KIND_USED;
                else
                    tok_next.kind = KIND_FREE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_FREE;
            tok_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== design/bbra_map_cell.sv =====
module bbra_map_cell import bbra_pkg::*; #(
    parameter int                 CELL_IDX = 0,
    parameter int                 SP_W     = 3,
    parameter logic [BLOCK_W-1:0] TGT      = '0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  map_ctl_t        ctl,
    input  logic [SP_W-1:0] spares_used,
    input  map_tok_t        tok_in,
    output map_tok_t        tok_out
);

    localparam logic [SP_W-1:0] MY_IDX = SP_W'(CELL_IDX);

    logic [BLOCK_W-1:0] bad_num_reg;
    map_tok_t           tok_reg;
    map_tok_t           tok_next;

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.found && (MY_IDX < spares_used)
            && (bad_num_reg == ctl.key))
        begin
            tok_next.found  = 1'b1;
            tok_next.target = TGT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.we && (spares_used == MY_IDX))
        begin
            bad_num_reg <= ctl.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== design/bad_block_remap_allocator.sv =====
// Bad block remapping allocator.
// req channel (valid/ready) carries opcode, block and run_length; rsp channel
// (valid/ready) returns status, target_block, redirected, bad_skipped and
// block_kind, one rsp item for every req item, in order.
// One item is worked on at a time. Each item is decoded, then may pass down
// a row of cells, then is loaded into the output register:
//   add bad block, out of range, range past disk: no row is passed
//   access: the remap entry row (one remap entry cell per cycle)
//   allocate, query: the block cell row (one block cell per cycle)
// The block cell row sets the allocation time; every block cell is visited.
// A finished result sits in the output register while the next req item is
// accepted and processed; if rsp stays stalled, a finished item waits
// inside the block until the output register empties.
// Reset clears every block to free, the remap fill count to zero and both
// channels to idle; remap entries need no clearing, only filled ones are read.
module bad_block_remap_allocator import bbra_pkg::*; #(
    parameter int NUM_BLOCKS = 32,
    parameter int NUM_SPARES = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    bbra_in_if.sink   req,
    bbra_out_if.source rsp
);

    localparam int SP_W           = $clog2(NUM_SPARES + 1);
    localparam int SPARE_BASE_BLK = (NUM_BLOCKS > NUM_SPARES) ? (NUM_BLOCKS - NUM_SPARES) : 0;

    ctl_state_t         state_reg;
    ctl_state_t         state_next;
    op_t                op_reg;
    logic [BLOCK_W-1:0] blk_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [SP_W-1:0]    spares_used_reg;
    logic [SP_W-1:0]    spares_used_next;
    rsp_t               res_reg;
    rsp_t               res_next;
    rsp_t               out_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_load;

    logic out_of_disk;
    logic past_disk;
    logic no_spare;
    logic launch_blk;
    logic launch_map;
    logic bad_we;
    logic map_we;
    logic req_ready;

    blk_ctl_t bctl;
    map_ctl_t mctl;
    blk_tok_t btok [NUM_BLOCKS+1];
    map_tok_t mtok [NUM_SPARES+1];

    assign out_of_disk = int'(blk_reg) >= NUM_BLOCKS;
    assign past_disk   = (int'(blk_reg) + int'(len_reg)) > NUM_BLOCKS;
    assign no_spare    = spares_used_reg >= SP_W'(NUM_SPARES);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                priority if (out_of_disk)
                    state_next = S_FINISH;
                else if (op_reg == OP_ALLOC && !past_disk)
                    state_next = S_BSCAN;
                else if (op_reg == OP_QUERY)
                    state_next = S_BSCAN;
                else if (op_reg == OP_ACCESS)
                    state_next = S_MSCAN;
                else
                    state_next = S_FINISH;
            end
            S_BSCAN:
            begin
                if (btok[NUM_BLOCKS].valid)
                    state_next = S_FINISH;
            end
            S_MSCAN:
            begin
                if (mtok[NUM_SPARES].valid)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req_ready        = 1'b0;
        launch_blk       = 1'b0;
        launch_map       = 1'b0;
        bad_we           = 1'b0;
        map_we           = 1'b0;
        out_load         = 1'b0;
        spares_used_next = spares_used_reg;
        res_next         = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
            end
            S_EXEC:
            begin
                res_next.status     = STS_OK;
                res_next.target     = blk_reg;
                res_next.redirected = 1'b0;
                res_next.skipped    = '0;
                res_next.kind       = KIND_FREE;
                priority if (out_of_disk)
                begin
                    res_next.status = STS_RANGE;
                end
                else if (op_reg == OP_ADD_BAD)
                begin
                    if (no_spare)
                    begin
                        res_next.status = STS_NO_SPARE;
                    end
                    else
                    begin
                        bad_we           = 1'b1;
                        map_we           = 1'b1;
                        spares_used_next = spares_used_reg + SP_W'(1);
                    end
                end
                else if (op_reg == OP_ALLOC)
                begin
                    if (past_disk)
                        res_next.status = STS_RANGE;
                    else
                        launch_blk = 1'b1;
                end
                else if (op_reg == OP_ACCESS)
                begin
                    launch_map = 1'b1;
                end
                else
                begin
                    launch_blk = 1'b1;
                end
            end
            S_BSCAN:
            begin
                if (btok[NUM_BLOCKS].valid)
                begin
                    res_next.status  = btok[NUM_BLOCKS].conflict ? STS_ALLOCATED : STS_OK;
                    res_next.skipped = btok[NUM_BLOCKS].skipped;
                    res_next.kind    = btok[NUM_BLOCKS].kind;
                end
            end
            S_MSCAN:
            begin
                if (mtok[NUM_SPARES].valid && mtok[NUM_SPARES].found)
                begin
                    res_next.target     = mtok[NUM_SPARES].target;
                    res_next.redirected = 1'b1;
                end
            end
            S_FINISH:
            begin
                out_load = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            spares_used_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            spares_used_reg <= spares_used_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req_ready)
        begin
            op_reg  <= op_t'(req.opcode);
            blk_reg <= req.block;
            len_reg <= req.run_length;
        end
        res_reg <= res_next;
        if (out_load)
        begin
            out_reg <= res_reg;
        end
    end

    // block cell row
    assign bctl.alloc_mode = (op_reg == OP_ALLOC);
    assign bctl.bad_we     = bad_we;
    assign bctl.first      = blk_reg;
    assign bctl.stop       = {{(STOP_W-BLOCK_W){1'b0}}, blk_reg}
                             + {{(STOP_W-LEN_W){1'b0}}, len_reg};

    assign btok[0].valid    = launch_blk;
    assign btok[0].live     = 1'b1;
    assign btok[0].conflict = 1'b0;
    assign btok[0].skipped  = '0;
    assign btok[0].kind     = KIND_FREE;

    for (genvar g = 0; g < NUM_BLOCKS; g++)
    begin : g_blk
        bbra_block_cell #(
            .CELL_IDX (g),
            .IS_SPARE (g >= SPARE_BASE_BLK)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (bctl),
            .tok_in  (btok[g]),
            .tok_out (btok[g+1])
        );
    end

    // remap entry row
    assign mctl.we  = map_we;
    assign mctl.key = blk_reg;

    assign mtok[0].valid  = launch_map;
    assign mtok[0].found  = 1'b0;
    assign mtok[0].target = blk_reg;

    for (genvar g = 0; g < NUM_SPARES; g++)
    begin : g_map
        bbra_map_cell #(
            .CELL_IDX (g),
            .SP_W     (SP_W),
            .TGT      (BLOCK_W'(SPARE_BASE_BLK + g))
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (mctl),
            .spares_used (spares_used_reg),
            .tok_in      (mtok[g]),
            .tok_out     (mtok[g+1])
        );
    end

    assign req.ready        = req_ready;
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_reg.status;
    assign rsp.target_block = out_reg.target;
    assign rsp.redirected   = out_reg.redirected;
    assign rsp.bad_skipped  = out_reg.skipped;
    assign rsp.block_kind   = out_reg.kind;

endmodule

// ===== design/bbra_checker.sv =====
`include "bad_block_remap_allocator_macros.svh"

module bbra_checker import bbra_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [BLOCK_W-1:0]  rsp_target,
    input logic                rsp_redirected,
    input logic [SKIP_W-1:0]   rsp_skipped,
    input logic [KIND_W-1:0]   rsp_kind
);

    `BBRA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `BBRA_ASSERT_NEXT(a_rsp_stable, clk, rst_n, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_target) && $stable(rsp_redirected) && $stable(rsp_skipped) && $stable(rsp_kind))
    `BBRA_ASSERT_IMP(a_redirect_ok, clk, rst_n, rsp_valid && rsp_redirected, rsp_status == STS_OK)
    `BBRA_ASSERT_IMP(a_range_clean, clk, rst_n, rsp_valid && rsp_status == STS_RANGE, rsp_skipped == '0 && rsp_kind == KIND_FREE && !rsp_redirected)
    `BBRA_ASSERT_IMP(a_kind_ok, clk, rst_n, rsp_valid && rsp_kind != KIND_FREE, rsp_status == STS_OK && !rsp_redirected)

endmodule

bind bad_block_remap_allocator bbra_checker u_bbra_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_target     (rsp.target_block),
    .rsp_redirected (rsp.redirected),
    .rsp_skipped    (rsp.bad_skipped),
    .rsp_kind       (rsp.block_kind)
);
